/* sv/rdrle_pkg.sv */
package rdrle_pkg;

  // One result item as it waits in the output queue
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  pixel_value;
    logic [19:0] run_length;
    logic [2:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        final_item;
  } res_t;

  // Item kinds
  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
  localparam logic [2:0] ST_BAD_HDR    = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  // Header magic letters
  localparam logic [7:0] MAGIC_R = 8'h52;
  localparam logic [7:0] MAGIC_D = 8'h44;

endpackage

/* sv/rd_image_rle_decoder_core.sv */
// A result item enters the output queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall is low; a byte yields at most two items
// (a run and the final status), which leave through a four-entry output queue at one item
// per cycle while out_stall is low. Input stalls while three or more items wait in the queue.
// Reset (synchronous, rst high) clears the decoder to the header phase and empties the queue;
// the byte marked end_of_source returns the decoder to the same state after its status item.
module rd_image_rle_decoder_core #(
  parameter int MAX_PIXELS = 100000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic [7:0]  pixel_value,
  output logic [19:0] run_length,
  output logic [2:0]  status,
  output logic [31:0] image_width,
  output logic [31:0] image_height,
  output logic        final_item
);
  import rdrle_pkg::*;

  localparam int PW = $clog2(MAX_PIXELS + 1);
  localparam int CW = (PW > 20) ? PW : 20;

  // Decode phases
  localparam logic [3:0] PH_HEADER     = 4'd0;
  localparam logic [3:0] PH_RAW        = 4'd1;
  localparam logic [3:0] PH_CMD        = 4'd2;
  localparam logic [3:0] PH_FILL_VALUE = 4'd3;
  localparam logic [3:0] PH_COUNT_MID  = 4'd4;
  localparam logic [3:0] PH_COUNT_LAST = 4'd5;
  localparam logic [3:0] PH_LITERAL    = 4'd6;
  localparam logic [3:0] PH_IDLE       = 4'd7;

  // Decoder state
  logic [31:0]   bp, bp_next;
  logic [31:0]   hw [4];
  logic [31:0]   hw_next [4];
  logic [3:0]    phase, phase_next;
  logic [7:0]    cmd, cmd_next;
  logic [19:0]   ca, ca_next;
  logic [7:0]    fv, fv_next;
  logic [PW-1:0] pr, pr_next;
  logic [2:0]    err, err_next;
  logic [63:0]   prod;

  // Per-byte results
  logic          run_v, st_v;
  res_t          run_item, st_item;
  logic          fill_go, lit_go, av_go;
  logic [19:0]   fill_cnt, lit_cnt;
  logic [7:0]    fill_val;
  logic [CW-1:0] fill_k, lit_k;
  logic [7:0]    av_cmd;
  logic          acc;

  // Output queue
  res_t          q [4];
  logic [1:0]    wp, rp;
  logic [2:0]    cnt;
  logic          pop;

  function automatic logic [CW-1:0] clamp(input logic [19:0] c, input logic [PW-1:0] p);
    logic [CW-1:0] ce;
    logic [CW-1:0] pe;
    ce = CW'(c);
    pe = CW'(p);
    return (ce > pe) ? pe : ce;
  endfunction

  assign acc      = in_valid && !in_stall;
  assign in_stall = (cnt > 3'd2);
  assign pop      = out_valid && !out_stall;

  // Next state and results for one byte
  always_comb begin
    bp_next    = (bp == 32'hFFFF_FFFF) ? bp : bp + 32'd1;
    hw_next    = hw;
    phase_next = phase;
    cmd_next   = cmd;
    ca_next    = ca;
    fv_next    = fv;
    pr_next    = pr;
    err_next   = err;
    run_v      = 1'b0;
    st_v       = 1'b0;
    run_item   = '0;
    st_item    = '0;
    fill_go    = 1'b0;
    fill_cnt   = '0;
    fill_val   = '0;
    lit_go     = 1'b0;
    lit_cnt    = '0;
    av_go      = 1'b0;
    av_cmd     = '0;
    fill_k     = '0;
    lit_k      = '0;

    if (bp < 32'd16) begin
      // header byte, little endian
      hw_next[bp[3:2]] = hw[bp[3:2]] | (32'(data_byte) << {bp[1:0], 3'b000});
      if (bp[3:0] == 4'hF) begin
        if (hw[0][7:0] != MAGIC_R || hw[0][15:8] != MAGIC_D
            || hw[1] == 32'd0 || hw[2] == 32'd0) begin
          err_next   = ST_BAD_HDR;
          phase_next = PH_IDLE;
        end else if (prod > 64'(MAX_PIXELS)) begin
          err_next   = ST_TOO_LARGE;
          phase_next = PH_IDLE;
        end else begin
          pr_next    = prod[PW-1:0];
          phase_next = (hw[0][23:16] != 8'd0) ? PH_CMD : PH_RAW;
        end
      end
    end else if (bp < hw[3]) begin
      // payload byte
      case (phase)
        PH_RAW: begin
          run_v    = 1'b1;
          run_item = '{KIND_RUN, data_byte, 20'd1, ST_OK, 32'd0, 32'd0, 1'b0};
          pr_next  = pr - PW'(1);
          if (pr_next == '0) phase_next = PH_IDLE;
        end
        PH_CMD: begin
          cmd_next = data_byte;
          if (data_byte[7]) begin
            if (data_byte[6]) begin
              fv_next  = 8'd0;
              fill_val = 8'd0;
              av_go    = 1'b1;
              av_cmd   = data_byte;
            end else begin
              phase_next = PH_FILL_VALUE;
            end
          end else if (data_byte[4]) begin
            ca_next    = {8'd0, data_byte[3:0], 8'd0};
            phase_next = PH_COUNT_LAST;
          end else begin
            lit_go  = 1'b1;
            lit_cnt = {16'd0, data_byte[3:0]};
          end
        end
        PH_FILL_VALUE: begin
          fv_next  = data_byte;
          fill_val = data_byte;
          av_go    = 1'b1;
          av_cmd   = cmd;
        end
        PH_COUNT_MID: begin
          ca_next    = ca | {4'd0, data_byte, 8'd0};
          phase_next = PH_COUNT_LAST;
        end
        PH_COUNT_LAST: begin
          if (cmd[7]) begin
            fill_go  = 1'b1;
            fill_cnt = ca | {12'd0, data_byte};
            fill_val = fv;
          end else begin
            lit_go  = 1'b1;
            lit_cnt = ca | {12'd0, data_byte};
          end
        end
        PH_LITERAL: begin
          run_v    = 1'b1;
          run_item = '{KIND_RUN, data_byte, 20'd1, ST_OK, 32'd0, 32'd0, 1'b0};
          ca_next  = ca - 20'd1;
          pr_next  = pr - PW'(1);
          if (pr_next == '0) phase_next = PH_IDLE;
          else if (ca_next == 20'd0) phase_next = PH_CMD;
        end
        default: begin
        end
      endcase
    end

    // fill command known: count bytes follow, or fill right away
    if (av_go) begin
      if (av_cmd[5]) begin
        ca_next    = {av_cmd[3:0], 16'd0};
        phase_next = PH_COUNT_MID;
      end else if (av_cmd[4]) begin
        ca_next    = {8'd0, av_cmd[3:0], 8'd0};
        phase_next = PH_COUNT_LAST;
      end else begin
        fill_go  = 1'b1;
        fill_cnt = {16'd0, av_cmd[3:0]};
      end
    end

    // data ended before the fill value: fill with zero
    if (!fill_go && phase_next == PH_FILL_VALUE && (end_of_source || bp_next >= hw_next[3])
        && cmd_next[5:4] == 2'b00) begin
      fv_next  = 8'd0;
      fill_go  = 1'b1;
      fill_cnt = {16'd0, cmd_next[3:0]};
      fill_val = 8'd0;
    end

    // fill run, clamped to the pixels left
    if (fill_go) begin
      fill_k = clamp(fill_cnt, pr);
      if (fill_k != '0) begin
        run_v    = 1'b1;
        run_item = '{KIND_RUN, fill_val, fill_k[19:0], ST_OK, 32'd0, 32'd0, 1'b0};
      end
      pr_next    = pr - fill_k[PW-1:0];
      phase_next = (pr_next != '0) ? PH_CMD : PH_IDLE;
    end

    // literal run start, clamped
    if (lit_go) begin
      lit_k      = clamp(lit_cnt, pr);
      ca_next    = lit_k[19:0];
      phase_next = (lit_k != '0) ? PH_LITERAL : PH_CMD;
    end

    // end of source: status item, then back to reset
    if (end_of_source) begin
      st_v               = 1'b1;
      st_item.item_kind  = KIND_STATUS;
      st_item.final_item = 1'b1;
      if (bp_next < 32'd16) begin
        st_item.status = ST_SHORT_HDR;
      end else begin
        st_item.image_width  = hw_next[1];
        st_item.image_height = hw_next[2];
        if (err_next != ST_OK) st_item.status = err_next;
        else st_item.status = (pr_next == '0) ? ST_OK : ST_INCOMPLETE;
      end
      bp_next    = '0;
      hw_next    = '{default: 32'd0};
      phase_next = PH_HEADER;
      cmd_next   = '0;
      ca_next    = '0;
      fv_next    = '0;
      pr_next    = '0;
      err_next   = ST_OK;
    end
  end

  // Decoder registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bp    <= '0;
      hw    <= '{default: 32'd0};
      phase <= PH_HEADER;
      cmd   <= '0;
      ca    <= '0;
      fv    <= '0;
      pr    <= '0;
      err   <= ST_OK;
    end else if (acc) begin
      bp    <= bp_next;
      hw    <= hw_next;
      phase <= phase_next;
      cmd   <= cmd_next;
      ca    <= ca_next;
      fv    <= fv_next;
      pr    <= pr_next;
      err   <= err_next;
    end
  end

  // Image area, taken once width and height are complete
  always_ff @(posedge clk) begin
    if (acc && bp == 32'd12) prod <= hw[1] * hw[2];
  end

  // Output queue payload
  always_ff @(posedge clk) begin
    if (acc && run_v) q[wp] <= run_item;
    if (acc && st_v) q[wp + 2'(run_v)] <= st_item;
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (acc) wp <= wp + 2'(run_v) + 2'(st_v);
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + (acc ? 3'(run_v) + 3'(st_v) : 3'd0) - 3'(pop);
    end
  end

  assign out_valid    = (cnt != 3'd0);
  assign item_kind    = q[rp].item_kind;
  assign pixel_value  = q[rp].pixel_value;
  assign run_length   = q[rp].run_length;
  assign status       = q[rp].status;
  assign image_width  = q[rp].image_width;
  assign image_height = q[rp].image_height;
  assign final_item   = q[rp].final_item;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("output queue overflow");

  a_eos_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && end_of_source) |=> (bp == 32'd0 && phase == PH_HEADER))
    else $error("decoder did not return to header after end of source");

  a_pixels_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RAW || phase == PH_CMD || phase == PH_LITERAL) |-> (pr != '0))
    else $error("decoding phase with no pixels remaining");

  a_literal_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LITERAL) |-> (ca != 20'd0))
    else $error("literal phase with zero count");

endmodule
